[hdl/fdab_pkg.sv]
package fdab_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_TEST_ON   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_WRITE_ON  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_COMPARE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_TEST_ON   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_REFERENCE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ON        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FORMAT   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXTURE_FORMAT  = 3'd7;

  localparam logic [3:0] DC_NEVER    = 4'd1;
  localparam logic [3:0] DC_LESS     = 4'd2;
  localparam logic [3:0] DC_EQUAL    = 4'd3;
  localparam logic [3:0] DC_LEQUAL   = 4'd4;
  localparam logic [3:0] DC_GREATER  = 4'd5;
  localparam logic [3:0] DC_NOTEQUAL = 4'd6;
  localparam logic [3:0] DC_GEQUAL   = 4'd7;
  localparam logic [3:0] DC_ALWAYS   = 4'd8;

  // pixel formats, shared by target and texture (texture code minus one)
  localparam logic [2:0] PF_ARGB1555 = 3'd0;
  localparam logic [2:0] PF_ARGB4444 = 3'd1;
  localparam logic [2:0] PF_RGB565   = 3'd2;
  localparam logic [2:0] PF_XRGB8888 = 3'd3;
  localparam logic [2:0] PF_ARGB8888 = 3'd4;

  localparam logic [2:0] TX_NONE = 3'd0;

  typedef struct packed {
    logic       depth_test_on;
    logic       depth_write_on;
    logic [3:0] depth_compare;
    logic       alpha_test_on;
    logic [7:0] alpha_reference;
    logic       blend_on;
    logic [2:0] target_format;
    logic [2:0] texture_format;
  } cfg_t;

  function automatic logic depth_passes(input logic [3:0] fn, input logic [15:0] nz,
                                        input logic [15:0] oz);
    logic pass;
    case (fn)
      DC_NEVER:    pass = 1'b0;
      DC_LESS:     pass = nz < oz;
      DC_EQUAL:    pass = nz == oz;
      DC_LEQUAL:   pass = nz <= oz;
      DC_GREATER:  pass = nz > oz;
      DC_NOTEQUAL: pass = nz != oz;
      DC_GEQUAL:   pass = nz >= oz;
      default:     pass = 1'b1;
    endcase
    return pass;
  endfunction

  function automatic logic [31:0] to_argb(input logic [2:0] fmt, input logic [31:0] w);
    logic [31:0] c;
    case (fmt)
      PF_ARGB1555: c = {{8{w[15]}}, w[14:10], 3'b0, w[9:5], 3'b0, w[4:0], 3'b0};
      PF_ARGB4444: c = {w[15:12], w[15:12], w[11:8], w[11:8],
                        w[7:4], w[7:4], w[3:0], w[3:0]};
      PF_RGB565:   c = {8'hFF, w[15:11], 3'b0, w[10:5], 2'b0, w[4:0], 3'b0};
      PF_XRGB8888: c = {8'hFF, w[23:0]};
      default:     c = w;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pack_target(input logic [2:0] fmt, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b);
    logic [31:0] c;
    case (fmt)
      PF_ARGB1555: c = {16'h0, 1'b1, r[7:3], g[7:3], b[7:3]};
      PF_ARGB4444: c = {16'h0, 4'hF, r[7:4], g[7:4], b[7:4]};
      PF_RGB565:   c = {16'h0, r[7:3], g[7:2], b[7:3]};
      default:     c = {8'h0, r, g, b};
    endcase
    return c;
  endfunction

  // truncating x / 255, exact for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'h0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

[hdl/fragment_depth_alpha_blend_stage.sv]
// Per-pixel raster back end: depth compare, texture modulate, alpha test,
// source-alpha blend against the destination, and pack into the target
// format. One item in and one result out per clock while m_tready is high;
// each item passes through five register stages (setup and depth test,
// modulate multiply, divide and alpha test, blend multiply, divide and pack).
// Each stage holds only while the one after it is full and stalled, so
// bubbles close up and s_tready falls only when all five are full.
// Configuration writes take effect at once and must come while no item is
// in the pipeline.
module fragment_depth_alpha_blend_stage
  import fdab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // frag_red, frag_green, frag_blue, diffuse_alpha, frag_depth,
  // stored_depth, texel_raw, dest_raw
  input  logic [127:0]           s_tdata,
  // diffuse_present
  input  logic [0:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // color_word, depth_word
  output logic [47:0]            m_tdata,
  // color_write, depth_write
  output logic [1:0]             m_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;

  fdab_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [5:1] v;
  logic [6:1] en;

  assign en[6] = m_tready;
  assign en[5] = ~v[5] | en[6];
  assign en[4] = ~v[4] | en[5];
  assign en[3] = ~v[3] | en[4];
  assign en[2] = ~v[2] | en[3];
  assign en[1] = ~v[1] | en[2];
  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_tvalid;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
      if (en[5]) v[5] <= v[4];
    end
  end

  // stage 1: depth test, texel unpack
  logic [7:0]  alpha_in;
  logic        depth_ok;
  logic [31:0] tex_in;

  assign alpha_in = s_tuser[0] ? s_tdata[31:24] : 8'hFF;
  assign depth_ok = ~cfg.depth_test_on
                    | depth_passes(cfg.depth_compare, s_tdata[47:32], s_tdata[63:48]);
  // no texture acts as white, which leaves the divide by 255 exact
  assign tex_in = (cfg.texture_format == TX_NONE) ? 32'hFFFF_FFFF
                  : to_argb(cfg.texture_format - 3'd1, s_tdata[95:64]);

  logic [7:0]  r1_ch [3];
  logic [7:0]  r1_alpha;
  logic [31:0] r1_tex;
  logic        r1_alive;
  logic [15:0] r1_depth;
  logic [31:0] r1_dest;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1_ch[0] <= s_tdata[7:0];
      r1_ch[1] <= s_tdata[15:8];
      r1_ch[2] <= s_tdata[23:16];
      r1_alpha <= alpha_in;
      r1_tex   <= tex_in;
      r1_alive <= depth_ok;
      r1_depth <= s_tdata[47:32];
      r1_dest  <= s_tdata[127:96];
    end
  end

  // stage 2: modulate products, destination unpack
  logic [15:0] r2_pa;
  logic [15:0] r2_pc [3];
  logic [23:0] r2_drgb;
  logic        r2_alive;
  logic [15:0] r2_depth;
  logic [31:0] dest_argb;

  assign dest_argb = to_argb((cfg.target_format > PF_ARGB8888) ? PF_ARGB8888
                             : cfg.target_format, r1_dest);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      r2_pa    <= 16'(r1_alpha) * 16'(r1_tex[31:24]);
      r2_pc[0] <= 16'(r1_ch[0]) * 16'(r1_tex[23:16]);
      r2_pc[1] <= 16'(r1_ch[1]) * 16'(r1_tex[15:8]);
      r2_pc[2] <= 16'(r1_ch[2]) * 16'(r1_tex[7:0]);
      r2_drgb  <= dest_argb[23:0];
      r2_alive <= r1_alive;
      r2_depth <= r1_depth;
    end
  end

  // stage 3: divide, alpha test
  logic [7:0] alpha_mod;

  assign alpha_mod = div255(r2_pa);

  logic [7:0]  r3_ch [3];
  logic [7:0]  r3_alpha;
  logic [23:0] r3_drgb;
  logic        r3_alive;
  logic [15:0] r3_depth;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r3_ch[0] <= div255(r2_pc[0]);
      r3_ch[1] <= div255(r2_pc[1]);
      r3_ch[2] <= div255(r2_pc[2]);
      r3_alpha <= alpha_mod;
      r3_drgb  <= r2_drgb;
      r3_alive <= r2_alive & ~(cfg.alpha_test_on & (alpha_mod <= cfg.alpha_reference));
      r3_depth <= r2_depth;
    end
  end

  // stage 4: blend products, full weight on the source when not blending
  logic [7:0] a_eff;
  logic [7:0] ia_eff;

  assign a_eff  = (cfg.blend_on && r3_alpha != 8'hFF) ? r3_alpha : 8'hFF;
  assign ia_eff = 8'hFF - a_eff;

  logic [15:0] r4_sum [3];
  logic        r4_alive;
  logic [15:0] r4_depth;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r4_sum[0] <= 16'(r3_ch[0]) * 16'(a_eff) + 16'(r3_drgb[23:16]) * 16'(ia_eff);
      r4_sum[1] <= 16'(r3_ch[1]) * 16'(a_eff) + 16'(r3_drgb[15:8]) * 16'(ia_eff);
      r4_sum[2] <= 16'(r3_ch[2]) * 16'(a_eff) + 16'(r3_drgb[7:0]) * 16'(ia_eff);
      r4_alive  <= r3_alive;
      r4_depth  <= r3_depth;
    end
  end

  // stage 5: divide, pack, output register
  logic [31:0] packed_color;

  assign packed_color = pack_target(cfg.target_format, div255(r4_sum[0]),
                                    div255(r4_sum[1]), div255(r4_sum[2]));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      m_tdata[31:0]  <= r4_alive ? packed_color : 32'h0;
      m_tdata[47:32] <= r4_depth;
      m_tuser[0]     <= r4_alive;
      m_tuser[1]     <= r4_alive & cfg.depth_write_on;
    end
  end

  assign m_tvalid = v[5];

`ifndef ASSERT_OFF
  a_depth_write_needs_color: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("depth write without color write");

  a_killed_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'h0)
    else $error("killed item carries color");

  a_top_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:24] == 8'h0)
    else $error("color word top byte set");

  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (cfg.target_format == PF_ARGB1555 || cfg.target_format == PF_ARGB4444
                 || cfg.target_format == PF_RGB565) |-> m_tdata[31:16] == 16'h0)
    else $error("16-bit target with upper half set");

  a_ready_low_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v == 5'b11111)
    else $error("ready low with a bubble in the pipeline");
`endif

endmodule

[hdl/fdab_cfg_regs.sv]
module fdab_cfg_regs
  import fdab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_test_on   <= 1'b0;
      cfg.depth_write_on  <= 1'b0;
      cfg.depth_compare   <= DC_ALWAYS;
      cfg.alpha_test_on   <= 1'b0;
      cfg.alpha_reference <= 8'h0;
      cfg.blend_on        <= 1'b0;
      cfg.target_format   <= PF_XRGB8888;
      cfg.texture_format  <= TX_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_TEST_ON:   cfg.depth_test_on   <= cfg_data[0];
        REG_DEPTH_WRITE_ON:  cfg.depth_write_on  <= cfg_data[0];
        REG_DEPTH_COMPARE:   cfg.depth_compare   <= cfg_data[3:0];
        REG_ALPHA_TEST_ON:   cfg.alpha_test_on   <= cfg_data[0];
        REG_ALPHA_REFERENCE: cfg.alpha_reference <= cfg_data;
        REG_BLEND_ON:        cfg.blend_on        <= cfg_data[0];
        REG_TARGET_FORMAT:   cfg.target_format   <= cfg_data[2:0];
        REG_TEXTURE_FORMAT:  cfg.texture_format  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule
